>>> hdl/gkms_pkg.sv
// ----------------------------------------------------------------------------
// gkms_pkg
// Shared constants, register codes and controller/datapath signal groups for
// the grid keypoint max select block.
// ----------------------------------------------------------------------------
package gkms_pkg;

   // default sizes
   localparam int MAX_CELLS_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;

   // fixed field widths
   localparam int CNT_W      = 7;
   localparam int RECIP_W    = 25;
   localparam int STRENGTH_W = 16;

   // fixed point formats: positions Q.4, reciprocals Q1.24
   localparam int POS_FRAC_BITS   = 4;
   localparam int RECIP_FRAC_BITS = 24;
   localparam int BIN_SHIFT       = POS_FRAC_BITS + RECIP_FRAC_BITS;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS   = 2'd0,
      CSR_GRID_ROWS   = 2'd1,
      CSR_RECIP_WIDTH = 2'd2,
      CSR_RECIP_HEIGHT = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [CNT_W-1:0]   GRID_COLS_RST = 7'd8;
   localparam logic [CNT_W-1:0]   GRID_ROWS_RST = 7'd8;
   localparam logic [RECIP_W-1:0] RECIP_RST     = 25'd524288;

   // request opcodes
   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic mul;
      logic idx;
      logic rd_offer;
      logic rd_flush;
      logic wr;
      logic ptr_clr;
      logic ptr_inc;
      logic occ_clr;
      logic out_load;
      logic out_empty;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic req_flush;
      logic occ_any;
      logic occ_ptr;
      logic last_hit;
      logic out_free;
   } dp_status_type;

endpackage

>>> hdl/gkms_if.sv
// ----------------------------------------------------------------------------
// gkms_if
// Channel interfaces: keypoint request, selection response, register write.
// ----------------------------------------------------------------------------
interface gkms_req_if #(
   parameter int COORD_BITS = gkms_pkg::COORD_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic [COORD_BITS-1:0]           pos_x;
   logic [COORD_BITS-1:0]           pos_y;
   logic [gkms_pkg::STRENGTH_W-1:0] strength;

   modport source (output valid, opcode, pos_x, pos_y, strength, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, strength, output ready);
endinterface

interface gkms_rsp_if #(
   parameter int COORD_BITS = gkms_pkg::COORD_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic [COORD_BITS-1:0]           out_x;
   logic [COORD_BITS-1:0]           out_y;
   logic [gkms_pkg::STRENGTH_W-1:0] out_strength;
   logic                            empty_res;
   logic                            last;

   modport source (output valid, out_x, out_y, out_strength, empty_res, last,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_strength, empty_res, last,
                   output ready);
endinterface

interface gkms_csr_if;
   logic                            valid;
   logic                            ready;
   logic [gkms_pkg::CSR_IDX_W-1:0]  index;
   logic [gkms_pkg::CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

>>> hdl/gkms_ctrl.sv
// ----------------------------------------------------------------------------
// gkms_ctrl
// Sequencer: offer read-modify-write steps and the flush walk over the cells.
// ----------------------------------------------------------------------------
module gkms_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gkms_pkg::dp_status_type status,
   output gkms_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_IDX   = 8'b0000_0100,
      S_RD    = 8'b0000_1000,
      S_WR    = 8'b0001_0000,
      S_SCAN  = 8'b0010_0000,
      S_LOAD  = 8'b0100_0000,
      S_EMPTY = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!status.req_flush) begin
                  state_in = S_MUL;
               end else if (status.occ_any) begin
                  cmd.ptr_clr = 1'b1;
                  state_in    = S_SCAN;
               end else begin
                  state_in = S_EMPTY;
               end
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_IDX;
         end
         S_IDX: begin
            cmd.idx  = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.rd_offer = 1'b1;
            state_in     = S_WR;
         end
         S_WR: begin
            cmd.wr   = 1'b1;
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (status.occ_ptr) begin
               cmd.rd_flush = 1'b1;
               cmd.occ_clr  = 1'b1;
               state_in     = S_LOAD;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.last_hit) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_inc = 1'b1;
                  state_in    = S_SCAN;
               end
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.out_empty = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/gkms_dp.sv
// ----------------------------------------------------------------------------
// gkms_dp
// Datapath: registers, grid binning, cell memory, occupancy and result buffer.
// ----------------------------------------------------------------------------
module gkms_dp #(
   parameter int MAX_CELLS  = gkms_pkg::MAX_CELLS_DEF,
   parameter int COORD_BITS = gkms_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gkms_pkg::ctrl_cmd_type          cmd,
   output gkms_pkg::dp_status_type         status,
   // request payload
   input  logic                            req_opcode,
   input  logic [COORD_BITS-1:0]           req_pos_x,
   input  logic [COORD_BITS-1:0]           req_pos_y,
   input  logic [gkms_pkg::STRENGTH_W-1:0] req_strength,
   // register writes
   input  logic                            csr_we,
   input  logic [gkms_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gkms_pkg::CSR_DATA_W-1:0] csr_wdata,
   // response
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [COORD_BITS-1:0]           rsp_out_x,
   output logic [COORD_BITS-1:0]           rsp_out_y,
   output logic [gkms_pkg::STRENGTH_W-1:0] rsp_out_strength,
   output logic                            rsp_empty_res,
   output logic                            rsp_last
);

   localparam int CNT_W  = gkms_pkg::CNT_W;
   localparam int STR_W  = gkms_pkg::STRENGTH_W;
   localparam int RCP_W  = gkms_pkg::RECIP_W;
   localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int PROD_W = COORD_BITS + RCP_W;
   localparam int IXR_W  = PROD_W - gkms_pkg::BIN_SHIFT;
   localparam int CMP_W  = (IXR_W > CNT_W) ? IXR_W : CNT_W;
   localparam int LIN_W  = 2 * CNT_W;
   localparam int WORD_W = 2 * COORD_BITS + STR_W;
   localparam int LIM_N  = 2 ** CNT_W;

   // configuration registers
   logic [CNT_W-1:0] cfg_cols_ff;
   logic [CNT_W-1:0] cfg_rows_ff;
   logic [RCP_W-1:0] cfg_rw_ff;
   logic [RCP_W-1:0] cfg_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= gkms_pkg::GRID_COLS_RST;
         cfg_rows_ff <= gkms_pkg::GRID_ROWS_RST;
         cfg_rw_ff   <= gkms_pkg::RECIP_RST;
         cfg_rh_ff   <= gkms_pkg::RECIP_RST;
      end else if (csr_we) begin
         case (gkms_pkg::csr_index_type'(csr_index))
            gkms_pkg::CSR_GRID_COLS:    cfg_cols_ff <= csr_wdata[CNT_W-1:0];
            gkms_pkg::CSR_GRID_ROWS:    cfg_rows_ff <= csr_wdata[CNT_W-1:0];
            gkms_pkg::CSR_RECIP_WIDTH:  cfg_rw_ff   <= csr_wdata[RCP_W-1:0];
            gkms_pkg::CSR_RECIP_HEIGHT: cfg_rh_ff   <= csr_wdata[RCP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // row limit table: max cells divided by column count
   logic [CNT_W-1:0] row_lim [LIM_N];

   for (genvar Col = 0; Col < LIM_N; Col++) begin : g_row_lim
      localparam int LIM = (Col == 0) ? MAX_CELLS : MAX_CELLS / ((Col == 0) ? 1 : Col);
      assign row_lim[Col] = CNT_W'(LIM);
   end

   // effective grid size
   logic [CNT_W-1:0] cols_c;
   logic [CNT_W-1:0] rows_c;
   logic [CNT_W-1:0] rows_max;

   always_comb begin
      if (cfg_cols_ff == '0) begin
         cols_c = CNT_W'(1);
      end else if (cfg_cols_ff > CNT_W'(MAX_CELLS)) begin
         cols_c = CNT_W'(MAX_CELLS);
      end else begin
         cols_c = cfg_cols_ff;
      end
      rows_max = row_lim[cols_c];
      if (cfg_rows_ff == '0) begin
         rows_c = CNT_W'(1);
      end else if (cfg_rows_ff > rows_max) begin
         rows_c = rows_max;
      end else begin
         rows_c = cfg_rows_ff;
      end
   end

   // captured request
   logic [COORD_BITS-1:0] x_ff;
   logic [COORD_BITS-1:0] y_ff;
   logic [STR_W-1:0]      s_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_pos_x;
         y_ff <= req_pos_y;
         s_ff <= req_strength;
      end
   end

   // binning products
   logic [PROD_W-1:0] prod_x_ff;
   logic [PROD_W-1:0] prod_y_ff;
   logic [CNT_W-1:0]  cols_ff;
   logic [CNT_W-1:0]  rows_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_x_ff <= PROD_W'(x_ff) * PROD_W'(cfg_rw_ff);
         prod_y_ff <= PROD_W'(y_ff) * PROD_W'(cfg_rh_ff);
         cols_ff   <= cols_c;
         rows_ff   <= rows_c;
      end
   end

   // clamp column and row, form linear cell index
   logic [CMP_W-1:0]  ix_ext;
   logic [CMP_W-1:0]  iy_ext;
   logic [CNT_W-1:0]  ix_c;
   logic [CNT_W-1:0]  iy_c;
   logic [LIN_W-1:0]  lin_idx;
   logic [CELL_W-1:0] idx_c;
   logic [CELL_W-1:0] idx_ff;

   always_comb begin
      ix_ext = CMP_W'(prod_x_ff >> gkms_pkg::BIN_SHIFT);
      iy_ext = CMP_W'(prod_y_ff >> gkms_pkg::BIN_SHIFT);
      if (ix_ext > CMP_W'(cols_ff - CNT_W'(1))) begin
         ix_c = cols_ff - CNT_W'(1);
      end else begin
         ix_c = CNT_W'(ix_ext);
      end
      if (iy_ext > CMP_W'(rows_ff - CNT_W'(1))) begin
         iy_c = rows_ff - CNT_W'(1);
      end else begin
         iy_c = CNT_W'(iy_ext);
      end
      lin_idx = LIN_W'(ix_c) + LIN_W'(iy_c) * LIN_W'(cols_ff);
      if (lin_idx >= LIN_W'(MAX_CELLS)) begin
         idx_c = CELL_W'(MAX_CELLS - 1);
      end else begin
         idx_c = CELL_W'(lin_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.idx) begin
         idx_ff <= idx_c;
      end
   end

   // flush pointer
   logic [CELL_W-1:0] ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_clr) begin
         ptr_ff <= '0;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + CELL_W'(1);
      end
   end

   // cell memory: {x, y, strength}
   logic [WORD_W-1:0] cell_mem [MAX_CELLS];
   logic [WORD_W-1:0] rd_word_ff;
   logic [CELL_W-1:0] rd_addr;
   logic [STR_W-1:0]  rd_strength;
   logic [MAX_CELLS-1:0] occ_ff;
   logic              update;

   assign rd_addr     = cmd.rd_flush ? ptr_ff : idx_ff;
   assign rd_strength = rd_word_ff[STR_W-1:0];
   assign update      = !occ_ff[idx_ff] || (s_ff > rd_strength);

   always_ff @(posedge clock) begin
      if (cmd.wr && update) begin
         cell_mem[idx_ff] <= {x_ff, y_ff, s_ff};
      end
      if (cmd.rd_offer || cmd.rd_flush) begin
         rd_word_ff <= cell_mem[rd_addr];
      end
   end

   // occupancy bits
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         if (cmd.wr && update) begin
            occ_ff[idx_ff] <= 1'b1;
         end
         if (cmd.occ_clr) begin
            occ_ff[ptr_ff] <= 1'b0;
         end
      end
   end

   // occupied cells beyond the pointer
   logic [MAX_CELLS-1:0] above;

   always_comb begin
      for (int j = 0; j < MAX_CELLS; j++) begin
         above[j] = occ_ff[j] && (CELL_W'(j) > ptr_ff);
      end
   end

   // result buffer
   logic                  out_valid_ff;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_y_ff;
   logic [STR_W-1:0]      out_s_ff;
   logic                  out_empty_ff;
   logic                  out_last_ff;
   logic                  out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_empty) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_x_ff     <= rd_word_ff[WORD_W-1 -: COORD_BITS];
         out_y_ff     <= rd_word_ff[STR_W +: COORD_BITS];
         out_s_ff     <= rd_strength;
         out_empty_ff <= 1'b0;
         out_last_ff  <= !(|above);
      end else if (cmd.out_empty) begin
         out_x_ff     <= '0;
         out_y_ff     <= '0;
         out_s_ff     <= '0;
         out_empty_ff <= 1'b1;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_strength = out_s_ff;
   assign rsp_empty_res    = out_empty_ff;
   assign rsp_last         = out_last_ff;

   // status to controller
   always_comb begin
      status.req_flush = (req_opcode == gkms_pkg::OP_FLUSH);
      status.occ_any   = |occ_ff;
      status.occ_ptr   = occ_ff[ptr_ff];
      status.last_hit  = !(|above);
      status.out_free  = out_free;
   end

endmodule

>>> hdl/grid_keypoint_max_select_top.sv
// ----------------------------------------------------------------------------
// grid_keypoint_max_select_top
// Keeps the strongest keypoint of each grid cell and emits them on flush.
// ----------------------------------------------------------------------------
// A keypoint offer occupies the block from its transfer until the request
// channel is ready again: capture, two binning multiplies, index clamp
// and linearization, then a read and a conditional write of the cell
// memory. A flush walks the cells one per cycle from cell 0 to the last
// occupied one and reads each kept keypoint out into the result buffer,
// waiting while the response channel stalls; a flush of an empty grid emits
// a single empty marker. Registers are written through the csr channel,
// which is always ready; the user is to write them only while no item is in
// flight; the block itself does not enforce it. Cells not yet written reset
// to empty through flip-flop occupancy bits, with no clearing pass.
module grid_keypoint_max_select_top #(
   parameter int MAX_CELLS  = gkms_pkg::MAX_CELLS_DEF,
   parameter int COORD_BITS = gkms_pkg::COORD_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   gkms_req_if.sink   req_chan,
   gkms_rsp_if.source rsp_chan,
   gkms_csr_if.sink   csr_chan
);

   gkms_pkg::ctrl_cmd_type  cmd;
   gkms_pkg::dp_status_type status;
   logic                    csr_we;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;
   assign csr_we         = csr_chan.valid;

   // sequencer
   gkms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   gkms_dp #(
      .MAX_CELLS  (MAX_CELLS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_chan.opcode),
      .req_pos_x        (req_chan.pos_x),
      .req_pos_y        (req_chan.pos_y),
      .req_strength     (req_chan.strength),
      .csr_we           (csr_we),
      .csr_index        (csr_chan.index),
      .csr_wdata        (csr_chan.wdata),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_out_x        (rsp_chan.out_x),
      .rsp_out_y        (rsp_chan.out_y),
      .rsp_out_strength (rsp_chan.out_strength),
      .rsp_empty_res    (rsp_chan.empty_res),
      .rsp_last         (rsp_chan.last)
   );

endmodule

>>> hdl/gkms_checker.sv
// ----------------------------------------------------------------------------
// gkms_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gkms_checker #(
   parameter int COORD_BITS = gkms_pkg::COORD_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [COORD_BITS-1:0]           rsp_out_x,
   input logic [COORD_BITS-1:0]           rsp_out_y,
   input logic [gkms_pkg::STRENGTH_W-1:0] rsp_out_strength,
   input logic                            rsp_empty_res,
   input logic                            rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_strength)
         && $stable(rsp_empty_res) && $stable(rsp_last))
      else $error("stalled result changed");

   // the empty marker closes its flush run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty marker without last");

   // the empty marker carries no keypoint
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_out_x == '0 && rsp_out_y == '0
         && rsp_out_strength == '0)
      else $error("empty marker with payload");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind grid_keypoint_max_select_top gkms_checker #(
   .COORD_BITS (COORD_BITS)
) u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_x        (rsp_chan.out_x),
   .rsp_out_y        (rsp_chan.out_y),
   .rsp_out_strength (rsp_chan.out_strength),
   .rsp_empty_res    (rsp_chan.empty_res),
   .rsp_last         (rsp_chan.last)
);
